@@ hw/rtl/hlc_pkg.sv @@
// Shared types and codes for the Huffman letter codec.
// No dependencies; used by every module of the block.
package hlc_pkg;

    localparam int FUNC_W     = 3;
    localparam int LETTER_W   = 5;
    localparam int VALUE_W    = 24;
    localparam int STATUS_W   = 2;
    localparam int CODE_W     = 25;
    localparam int CODE_LEN_W = 5;

    localparam logic [FUNC_W-1:0] FN_COUNT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_BUILD  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DECODE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_ENCODE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_LETTERS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNUSABLE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT     = 2'd3;

    // control broadcast to every cell of the ordered list
    typedef struct packed {
        logic clr;   // empty the list
        logic ins;   // insert the new entry in weight order
        logic pop2;  // drop the first two entries
    } list_ctrl_t;

endpackage

@@ hw/rtl/hlc_cell.sv @@
// One cell of the weight-ordered list: holds one node index and its weight.
// Depends on hlc_pkg; instantiated in a row by huffman_letter_codec.
module hlc_cell
    import hlc_pkg::*;
#(
    parameter int NW = 6,
    parameter int WW = 29
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  list_ctrl_t    ctrl,
    input  logic          head,
    input  logic [NW-1:0] new_node,
    input  logic [WW-1:0] new_weight,
    input  logic          prev_valid,
    input  logic [NW-1:0] prev_node,
    input  logic [WW-1:0] prev_weight,
    input  logic          prev_past,
    input  logic          far_valid,
    input  logic [NW-1:0] far_node,
    input  logic [WW-1:0] far_weight,
    output logic          valid,
    output logic [NW-1:0] node,
    output logic [WW-1:0] weight,
    output logic          past
);

    logic          valid_reg, valid_next;
    logic [NW-1:0] node_reg, node_next;
    logic [WW-1:0] weight_reg, weight_next;
    logic          cond;

    // head takes a new entry of equal weight; the rest only go past heavier ones
    assign cond = !valid_reg || (weight_reg > new_weight)
                  || (head && weight_reg == new_weight);
    assign past = prev_past || cond;

    always_comb
    begin
        valid_next  = valid_reg;
        node_next   = node_reg;
        weight_next = weight_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.pop2)
        begin
            valid_next  = far_valid;
            node_next   = far_node;
            weight_next = far_weight;
        end
        else if (ctrl.ins && past)
        begin
            if (head || !prev_past)
            begin
                valid_next  = 1'b1;
                node_next   = new_node;
                weight_next = new_weight;
            end
            else
            begin
                valid_next  = prev_valid;
                node_next   = prev_node;
                weight_next = prev_weight;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        weight_reg <= weight_next;
    end

    assign valid  = valid_reg;
    assign node   = node_reg;
    assign weight = weight_reg;

endmodule

@@ hw/rtl/hlc_node_store.sv @@
// Tree node memory (children, leaf flag, letter) and parent memory (parent, side).
// Depends on hlc_pkg; instantiated by huffman_letter_codec.
module hlc_node_store
    import hlc_pkg::*;
#(
    parameter int NODES = 51,
    parameter int NW    = 6,
    parameter int LW    = 5
)
(
    input  logic          clk,
    input  logic          node_we,
    input  logic [NW-1:0] node_waddr,
    input  logic [NW-1:0] node_wleft,
    input  logic [NW-1:0] node_wright,
    input  logic          node_wleaf,
    input  logic [LW-1:0] node_wletter,
    input  logic [NW-1:0] node_raddr,
    output logic [NW-1:0] node_rleft,
    output logic [NW-1:0] node_rright,
    output logic          node_rleaf,
    output logic [LW-1:0] node_rletter,
    input  logic          par_we,
    input  logic [NW-1:0] par_waddr,
    input  logic [NW-1:0] par_wparent,
    input  logic          par_wside,
    input  logic [NW-1:0] par_raddr,
    output logic [NW-1:0] par_rparent,
    output logic          par_rside
);

    localparam int NODE_DW = 2 * NW + 1 + LW;
    localparam int PAR_DW  = NW + 1;

    logic [NODE_DW-1:0] node_mem [NODES];
    logic [PAR_DW-1:0]  par_mem  [NODES];
    logic [NODE_DW-1:0] node_rdata_reg;
    logic [PAR_DW-1:0]  par_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= {node_wleft, node_wright, node_wleaf, node_wletter};
        end
        node_rdata_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_waddr] <= {par_wparent, par_wside};
        end
        par_rdata_reg <= par_mem[par_raddr];
    end

    assign {node_rleft, node_rright, node_rleaf, node_rletter} = node_rdata_reg;
    assign {par_rparent, par_rside} = par_rdata_reg;

endmodule

@@ hw/rtl/huffman_letter_codec.sv @@
// Top level of the Huffman letter codec: counts, build sequencer, codec walks.
// Depends on hlc_pkg, hlc_cell and hlc_node_store.
//
//  channel  | handshake          | fields
//  ---------+--------------------+------------------------------------------------
//  input    | in_valid/in_stall  | func, letter, count_value, code_bit
//  output   | out_valid/out_stall| status, symbol_valid, symbol, code_bits,
//           |                    | code_length
//
// One item at a time. Count and load give no result.
// Build scans every letter, then pops two entries and inserts their merge in the list row.
// Decode steps one level down the tree per code bit; encode climbs the parent memory to the root.
// Reset clears the counts and the list; node memories are written by the build.
// A stalled result sits in the output register; the next item is taken meanwhile.
module huffman_letter_codec
    import hlc_pkg::*;
#(
    parameter int ALPHABET_SIZE = 26,
    parameter int COUNT_WIDTH   = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [FUNC_W-1:0]     func,
    input  logic [LETTER_W-1:0]   letter,
    input  logic [VALUE_W-1:0]    count_value,
    input  logic                  code_bit,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic                  symbol_valid,
    output logic [LETTER_W-1:0]   symbol,
    output logic [CODE_W-1:0]     code_bits,
    output logic [CODE_LEN_W-1:0] code_length
);

    localparam int LW    = $clog2(ALPHABET_SIZE);
    localparam int NODES = 2 * ALPHABET_SIZE - 1;
    localparam int NW    = $clog2(NODES);
    localparam int WW    = COUNT_WIDTH + $clog2(ALPHABET_SIZE);
    localparam int CW    = COUNT_WIDTH;

    localparam logic [LW-1:0] LAST_LETTER = LW'(ALPHABET_SIZE - 1);
    localparam logic [CW-1:0] COUNT_MAX   = {CW{1'b1}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_POP  = 4'd3;
    localparam logic [3:0] S_INS  = 4'd4;
    localparam logic [3:0] S_FIN  = 4'd5;
    localparam logic [3:0] S_DA   = 4'd6;
    localparam logic [3:0] S_DB   = 4'd7;
    localparam logic [3:0] S_EWT  = 4'd8;
    localparam logic [3:0] S_PUSH = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [CW-1:0]         cnt_reg [ALPHABET_SIZE];
    logic                  present_reg [ALPHABET_SIZE];
    logic [NW-1:0]         leaf_idx_reg [ALPHABET_SIZE];
    logic                  tree_built_reg, tree_built_next;
    logic [NW-1:0]         root_reg, root_next;
    logic [NW-1:0]         cursor_reg, cursor_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [NW-1:0]         rem_reg, rem_next;
    logic [LW-1:0]         scan_reg, scan_next;
    logic [WW-1:0]         sum_reg, sum_next;
    logic [NW-1:0]         b_reg, b_next;
    logic                  bit_reg, bit_next;
    logic [CODE_LEN_W-1:0] k_reg, k_next;
    logic [CODE_W-1:0]     code_reg, code_next;

    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  res_symv_reg, res_symv_next;
    logic [LETTER_W-1:0]   res_sym_reg, res_sym_next;
    logic [CODE_W-1:0]     res_code_reg, res_code_next;
    logic [CODE_LEN_W-1:0] res_len_reg, res_len_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;
    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_symv_reg;
    logic [LETTER_W-1:0]   out_sym_reg;
    logic [CODE_W-1:0]     out_code_reg;
    logic [CODE_LEN_W-1:0] out_len_reg;

    logic                  accept;
    logic                  in_range;
    logic [LW-1:0]         lidx;
    logic [CW-1:0]         load_val;
    logic [CW-1:0]         cnt_cur;
    logic                  build_start;
    logic                  leaf_set;

    list_ctrl_t            lctrl;
    logic [NW-1:0]         new_node;
    logic [WW-1:0]         new_weight;
    logic                  c_valid  [ALPHABET_SIZE];
    logic [NW-1:0]         c_node   [ALPHABET_SIZE];
    logic [WW-1:0]         c_weight [ALPHABET_SIZE];
    logic                  c_past   [ALPHABET_SIZE];

    logic                  node_we;
    logic [NW-1:0]         node_wleft, node_wright, node_raddr;
    logic                  node_wleaf;
    logic [LW-1:0]         node_wletter;
    logic [NW-1:0]         node_rleft, node_rright;
    logic                  node_rleaf;
    logic [LW-1:0]         node_rletter;
    logic                  par_we;
    logic [NW-1:0]         par_waddr, par_wparent, par_raddr, par_rparent;
    logic                  par_wside, par_rside;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign in_range = (32'(letter) < ALPHABET_SIZE);
    assign lidx     = in_range ? letter[LW-1:0] : '0;
    assign load_val = CW'({{(64 - VALUE_W){1'b0}}, count_value});
    assign cnt_cur  = cnt_reg[scan_reg];

    // ordered list as a row of cells
    for (genvar i = 0; i < ALPHABET_SIZE; i++)
    begin : g_cell
        logic          pv, pp, fv;
        logic [NW-1:0] pn, fn;
        logic [WW-1:0] pw, fw;
        if (i == 0)
        begin : g_first
            assign pv = 1'b0;
            assign pn = '0;
            assign pw = '0;
            assign pp = 1'b0;
        end
        else
        begin : g_mid
            assign pv = c_valid[i-1];
            assign pn = c_node[i-1];
            assign pw = c_weight[i-1];
            assign pp = c_past[i-1];
        end
        if (i + 2 < ALPHABET_SIZE)
        begin : g_far
            assign fv = c_valid[i+2];
            assign fn = c_node[i+2];
            assign fw = c_weight[i+2];
        end
        else
        begin : g_end
            assign fv = 1'b0;
            assign fn = '0;
            assign fw = '0;
        end
        hlc_cell #(
            .NW(NW),
            .WW(WW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (lctrl),
            .head       (i == 0),
            .new_node   (new_node),
            .new_weight (new_weight),
            .prev_valid (pv),
            .prev_node  (pn),
            .prev_weight(pw),
            .prev_past  (pp),
            .far_valid  (fv),
            .far_node   (fn),
            .far_weight (fw),
            .valid      (c_valid[i]),
            .node       (c_node[i]),
            .weight     (c_weight[i]),
            .past       (c_past[i])
        );
    end

    hlc_node_store #(
        .NODES(NODES),
        .NW   (NW),
        .LW   (LW)
    ) u_store (
        .clk         (clk),
        .node_we     (node_we),
        .node_waddr  (n_reg),
        .node_wleft  (node_wleft),
        .node_wright (node_wright),
        .node_wleaf  (node_wleaf),
        .node_wletter(node_wletter),
        .node_raddr  (node_raddr),
        .node_rleft  (node_rleft),
        .node_rright (node_rright),
        .node_rleaf  (node_rleaf),
        .node_rletter(node_rletter),
        .par_we      (par_we),
        .par_waddr   (par_waddr),
        .par_wparent (par_wparent),
        .par_wside   (par_wside),
        .par_raddr   (par_raddr),
        .par_rparent (par_rparent),
        .par_rside   (par_rside)
    );

    always_comb
    begin
        state_next      = state_reg;
        tree_built_next = tree_built_reg;
        root_next       = root_reg;
        cursor_next     = cursor_reg;
        n_next          = n_reg;
        rem_next        = rem_reg;
        scan_next       = scan_reg;
        sum_next        = sum_reg;
        b_next          = b_reg;
        bit_next        = bit_reg;
        k_next          = k_reg;
        code_next       = code_reg;
        res_status_next = res_status_reg;
        res_symv_next   = res_symv_reg;
        res_sym_next    = res_sym_reg;
        res_code_next   = res_code_reg;
        res_len_next    = res_len_reg;
        build_start     = 1'b0;
        leaf_set        = 1'b0;
        lctrl           = '0;
        new_node        = n_reg;
        new_weight      = sum_reg;
        node_we         = 1'b0;
        node_wleft      = '0;
        node_wright     = '0;
        node_wleaf      = 1'b0;
        node_wletter    = '0;
        node_raddr      = cursor_reg;
        par_we          = 1'b0;
        par_waddr       = c_node[0];
        par_wparent     = n_reg;
        par_wside       = 1'b0;
        par_raddr       = leaf_idx_reg[lidx];
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_symv_next   = 1'b0;
                    res_sym_next    = '0;
                    res_code_next   = '0;
                    res_len_next    = '0;
                    case (func)
                        FN_BUILD:
                        begin
                            build_start     = 1'b1;
                            tree_built_next = 1'b0;
                            lctrl.clr       = 1'b1;
                            n_next          = '0;
                            scan_next       = '0;
                            state_next      = S_SCAN;
                        end
                        FN_DECODE:
                        begin
                            bit_next = code_bit;
                            if (!tree_built_reg)
                            begin
                                res_status_next = ST_UNUSABLE;
                                state_next      = S_PUSH;
                            end
                            else
                            begin
                                state_next = S_DA;
                            end
                        end
                        FN_ENCODE:
                        begin
                            k_next    = '0;
                            code_next = '0;
                            if (!tree_built_reg)
                            begin
                                res_status_next = ST_UNUSABLE;
                                state_next      = S_PUSH;
                            end
                            else if (!in_range || !present_reg[lidx])
                            begin
                                res_status_next = ST_ABSENT;
                                state_next      = S_PUSH;
                            end
                            else
                            begin
                                state_next = S_EWT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                new_weight = WW'(cnt_cur);
                if (cnt_cur != '0)
                begin
                    lctrl.ins    = 1'b1;
                    node_we      = 1'b1;
                    node_wleaf   = 1'b1;
                    node_wletter = scan_reg;
                    leaf_set     = 1'b1;
                    n_next       = n_reg + 1'b1;
                end
                if (scan_reg == LAST_LETTER)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_CHK:
            begin
                rem_next = n_reg - 1'b1;
                if (n_reg == '0)
                begin
                    res_status_next = ST_NO_LETTERS;
                    state_next      = S_PUSH;
                end
                else if (n_reg == NW'(1))
                begin
                    res_status_next = ST_UNUSABLE;
                    state_next      = S_PUSH;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                lctrl.pop2  = 1'b1;
                sum_next    = c_weight[0] + c_weight[1];
                b_next      = c_node[1];
                node_we     = 1'b1;
                node_wleft  = c_node[0];
                node_wright = c_node[1];
                par_we      = 1'b1;
                state_next  = S_INS;
            end
            S_INS:
            begin
                lctrl.ins = 1'b1;
                par_we    = 1'b1;
                par_waddr = b_reg;
                par_wside = 1'b1;
                n_next    = n_reg + 1'b1;
                if (rem_reg == NW'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rem_next   = rem_reg - 1'b1;
                    state_next = S_POP;
                end
            end
            S_FIN:
            begin
                root_next       = c_node[0];
                cursor_next     = c_node[0];
                tree_built_next = 1'b1;
                state_next      = S_PUSH;
            end
            S_DA:
            begin
                node_raddr  = bit_reg ? node_rright : node_rleft;
                cursor_next = node_raddr;
                state_next  = S_DB;
            end
            S_DB:
            begin
                if (node_rleaf)
                begin
                    res_symv_next = 1'b1;
                    res_sym_next  = LETTER_W'(node_rletter);
                    cursor_next   = root_reg;
                end
                state_next = S_PUSH;
            end
            S_EWT:
            begin
                // climb one level: side bit lands at the current depth from the leaf
                code_next = code_reg | (CODE_W'(par_rside) << k_reg);
                k_next    = k_reg + 1'b1;
                par_raddr = par_rparent;
                if (par_rparent == root_reg)
                begin
                    res_code_next = code_next;
                    res_len_next  = k_next;
                    state_next    = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tree_built_reg <= 1'b0;
            root_reg       <= '0;
            cursor_reg     <= '0;
            n_reg          <= '0;
            rem_reg        <= '0;
            scan_reg       <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tree_built_reg <= tree_built_next;
            root_reg       <= root_next;
            cursor_reg     <= cursor_next;
            n_reg          <= n_next;
            rem_reg        <= rem_next;
            scan_reg       <= scan_next;
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        b_reg          <= b_next;
        bit_reg        <= bit_next;
        code_reg       <= code_next;
        res_status_reg <= res_status_next;
        res_symv_reg   <= res_symv_next;
        res_sym_reg    <= res_sym_next;
        res_code_reg   <= res_code_next;
        res_len_reg    <= res_len_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_symv_reg   <= res_symv_reg;
            out_sym_reg    <= res_sym_reg;
            out_code_reg   <= res_code_reg;
            out_len_reg    <= res_len_reg;
        end
        if (leaf_set)
        begin
            leaf_idx_reg[scan_reg] <= n_reg;
        end
    end

    // letter counts: saturating count, or load of a new value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (accept && in_range)
        begin
            if (func == FN_COUNT && cnt_reg[lidx] != COUNT_MAX)
            begin
                cnt_reg[lidx] <= cnt_reg[lidx] + 1'b1;
            end
            else if (func == FN_LOAD)
            begin
                cnt_reg[lidx] <= load_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                present_reg[i] <= 1'b0;
            end
        end
        else if (build_start)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                present_reg[i] <= 1'b0;
            end
        end
        else if (leaf_set)
        begin
            present_reg[scan_reg] <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign symbol_valid = out_symv_reg;
    assign symbol       = out_sym_reg;
    assign code_bits    = out_code_reg;
    assign code_length  = out_len_reg;

    // a built tree leaves exactly the root in the list
    a_root_only: assert property (@(posedge clk) disable iff (!rst_n)
        tree_built_reg |-> (c_valid[0] && !c_valid[1]))
        else $error("list does not hold the root alone");

    a_symbol_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && symbol_valid) |-> (status == ST_OK))
        else $error("decoded letter with error status");

    a_walk_built: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EWT || state_reg == S_DA || state_reg == S_DB) |-> tree_built_reg)
        else $error("tree walk without a built tree");

    a_err_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (code_length == '0 && !symbol_valid))
        else $error("error item carries a code");

endmodule

@@ test/tb_huffman_letter_codec.sv @@
`timescale 1ns / 100ps
// Testbench for huffman_letter_codec: counts, tree builds, encode and decode.
// Depends on hlc_pkg and the codec RTL; predicts every result internally.
module tb_huffman_letter_codec;
    import hlc_pkg::*;

    localparam int NLET = 26;
    localparam int NNODE = 2 * NLET - 1;
    localparam int CMAX = 24'hFFFFFF;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [FUNC_W-1:0] func;
    logic [LETTER_W-1:0] letter;
    logic [VALUE_W-1:0] count_value;
    logic code_bit;
    logic out_valid;
    logic out_stall;
    logic [STATUS_W-1:0] status;
    logic symbol_valid;
    logic [LETTER_W-1:0] symbol;
    logic [CODE_W-1:0] code_bits;
    logic [CODE_LEN_W-1:0] code_length;

    huffman_letter_codec dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .letter(letter), .count_value(count_value),
        .code_bit(code_bit), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .symbol_valid(symbol_valid), .symbol(symbol),
        .code_bits(code_bits), .code_length(code_length)
    );

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic sv;
        logic [LETTER_W-1:0] sym;
        logic [CODE_W-1:0] code;
        logic [CODE_LEN_W-1:0] len;
    } codec_result_t;

    codec_result_t expected_results[$];

    // predictor state
    logic [23:0] cnt[NLET];
    logic [28:0] wt[NNODE];
    int lft[NNODE];
    int rgt[NNODE];
    bit leaf[NNODE];
    int nlet[NNODE];
    int olist[NLET];
    int olen;
    int root;
    bit built;
    int cursor;

    int errors;
    int mismatches;
    int results_seen;
    int items_sent;
    bit idle_en;
    bit hold_rx;

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void list_insert(int node);
        int pos;
        pos = olen;
        if (olen == 0 || wt[node] <= wt[olist[0]])
            pos = 0;
        else
            for (int i = 1; i < olen; i++)
                if (wt[olist[i]] > wt[node])
                begin
                    pos = i;
                    break;
                end
        for (int i = olen; i > pos; i--)
            olist[i] = olist[i - 1];
        olist[pos] = node;
        olen++;
    endfunction

    function automatic int list_pop();
        int first;
        first = olist[0];
        for (int i = 1; i < olen; i++)
            olist[i - 1] = olist[i];
        olen--;
        return first;
    endfunction

    function automatic logic [STATUS_W-1:0] build_tree();
        int n;
        int a;
        int b;
        n = 0;
        olen = 0;
        built = 0;
        for (int l = 0; l < NLET; l++)
            if (cnt[l] != 0)
            begin
                wt[n] = 29'(cnt[l]);
                leaf[n] = 1;
                nlet[n] = l;
                lft[n] = 0;
                rgt[n] = 0;
                list_insert(n);
                n++;
            end
        if (n == 0)
            return ST_NO_LETTERS;
        if (n == 1)
            return ST_UNUSABLE;
        for (int k = n; k > 1; k--)
        begin
            a = list_pop();
            b = list_pop();
            wt[n] = wt[a] + wt[b];
            lft[n] = a;
            rgt[n] = b;
            leaf[n] = 0;
            nlet[n] = 0;
            list_insert(n);
            n++;
        end
        root = olist[0];
        cursor = root;
        built = 1;
        return ST_OK;
    endfunction

    function automatic bit path_to(int node, int ltr, int depth, logic [CODE_W-1:0] bits,
                                   output logic [CODE_W-1:0] ob, output int ol);
        if (leaf[node])
        begin
            ob = bits;
            ol = depth;
            return nlet[node] == ltr;
        end
        if (path_to(lft[node], ltr, depth + 1, bits << 1, ob, ol))
            return 1;
        return path_to(rgt[node], ltr, depth + 1, (bits << 1) | CODE_W'(1), ob, ol);
    endfunction

    // returns 1 when the item produces a result
    function automatic bit predict_codec(logic [FUNC_W-1:0] f, logic [LETTER_W-1:0] l,
                                         logic [VALUE_W-1:0] v, logic b,
                                         output codec_result_t r);
        logic [CODE_W-1:0] cb;
        int cl;
        r = '0;
        case (f)
            FN_COUNT:
            begin
                if (l < NLET && cnt[l] != CMAX)
                    cnt[l] = cnt[l] + 24'd1;
                return 0;
            end
            FN_LOAD:
            begin
                if (l < NLET)
                    cnt[l] = v;
                return 0;
            end
            FN_BUILD:
                r.st = build_tree();
            FN_DECODE:
            begin
                if (!built)
                    r.st = ST_UNUSABLE;
                else
                begin
                    cursor = b ? rgt[cursor] : lft[cursor];
                    if (leaf[cursor])
                    begin
                        r.sv = 1;
                        r.sym = LETTER_W'(nlet[cursor]);
                        cursor = root;
                    end
                end
            end
            FN_ENCODE:
            begin
                if (!built)
                    r.st = ST_UNUSABLE;
                else if (l >= NLET || !path_to(root, l, 0, '0, cb, cl))
                    r.st = ST_ABSENT;
                else
                begin
                    r.code = cb;
                    r.len = CODE_LEN_W'(cl);
                end
            end
            default:
                return 0;
        endcase
        return 1;
    endfunction

    task automatic send_item(logic [FUNC_W-1:0] f, logic [LETTER_W-1:0] l,
                             logic [VALUE_W-1:0] v, logic b);
        codec_result_t r;
        while (idle_en && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        letter <= l;
        count_value <= v;
        code_bit <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_codec(f, l, v, b, r))
            expected_results = {expected_results, r};
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // receiver
    always @(posedge clk)
    begin
        if (hold_rx)
            out_stall <= 1'b1;
        else
            out_stall <= idle_en && ($urandom_range(99) < 26);
    end

    always @(posedge clk)
    begin
        codec_result_t want;
        codec_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, symbol_valid, symbol, code_bits, code_length};
            results_seen++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("unexpected result %p", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    task automatic decode_bits(int n);
        for (int i = 0; i < n; i++)
            send_item(FN_DECODE, LETTER_W'($urandom), VALUE_W'($urandom),
                      1'($urandom_range(1)));
    endtask

    task automatic test_no_tree();
        send_item(FN_DECODE, 0, 0, 1'b0);
        send_item(FN_ENCODE, 0, 0, 1'b0);
        send_item(FN_BUILD, 0, 0, 1'b0);
        send_item(FN_COUNT, 5'd7, 0, 1'b0);
        send_item(FN_BUILD, 0, 0, 1'b0);
        send_item(FN_ENCODE, 5'd7, 0, 1'b0);
        send_item(3'd5, 0, 0, 1'b0);
        send_item(3'd7, 5'd31, 24'hFFFFFF, 1'b1);
        send_item(FN_COUNT, 5'd31, 0, 1'b0);
        send_item(FN_LOAD, 5'd26, 24'h123456, 1'b0);
    endtask

    task automatic test_directed_tree();
        send_item(FN_LOAD, 5'd0, 24'hFFFFFF, 1'b0);
        send_item(FN_COUNT, 5'd0, 0, 1'b0);
        send_item(FN_LOAD, 5'd25, 24'd1, 1'b1);
        send_item(FN_LOAD, 5'd12, 24'hFFFFFE, 1'b0);
        send_item(FN_BUILD, 0, 0, 1'b0);
        send_item(FN_ENCODE, 5'd0, 0, 1'b0);
        send_item(FN_ENCODE, 5'd25, 0, 1'b0);
        send_item(FN_ENCODE, 5'd3, 0, 1'b0);
        send_item(FN_ENCODE, 5'd31, 0, 1'b0);
        send_item(FN_LOAD, 5'd3, 24'd9, 1'b0);
        send_item(FN_ENCODE, 5'd3, 0, 1'b0);
        decode_bits(6);
    endtask

    // all 26 letters with skewed power-of-two weights for deep codes
    task automatic test_full_alphabet();
        for (int l = 0; l < NLET; l++)
            send_item(FN_LOAD, LETTER_W'(l), 24'd1 << (l % 24), 1'b0);
        send_item(FN_BUILD, 0, 0, 1'b0);
        for (int l = 0; l < NLET; l++)
            send_item(FN_ENCODE, LETTER_W'(l), 0, 1'b0);
        decode_bits(60);
    endtask

    task automatic test_random(int n);
        int k;
        int sel;
        k = 0;
        while (k < n)
        begin
            if ($urandom_range(99) < 15)
            begin
                for (int l = 0; l < NLET; l++)
                begin
                    sel = $urandom_range(9);
                    send_item(FN_LOAD, LETTER_W'(l), VALUE_W'(sel < 3 ? 0 :
                              (sel < 8 ? $urandom_range(50) : $urandom)), 1'($urandom));
                end
                send_item(FN_BUILD, LETTER_W'($urandom), VALUE_W'($urandom), 1'($urandom));
                k += 27;
            end
            else
            begin
                sel = $urandom_range(99);
                if (sel < 40)
                    send_item(FN_DECODE, LETTER_W'($urandom), VALUE_W'($urandom),
                              1'($urandom));
                else if (sel < 70)
                    send_item(FN_ENCODE, LETTER_W'($urandom_range(31)), VALUE_W'($urandom),
                              1'($urandom));
                else if (sel < 85)
                    send_item(FN_COUNT, LETTER_W'($urandom_range(27)), VALUE_W'($urandom),
                              1'($urandom));
                else if (sel < 92)
                    send_item(FN_LOAD, LETTER_W'($urandom_range(27)), VALUE_W'($urandom),
                              1'($urandom));
                else if (sel < 97)
                    send_item(FN_BUILD, LETTER_W'($urandom), VALUE_W'($urandom),
                              1'($urandom));
                else
                    send_item(FUNC_W'($urandom_range(7)), LETTER_W'($urandom),
                              VALUE_W'($urandom), 1'($urandom));
                k++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_rx = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_rx = 1'b0;
            end
            for (int i = 0; i < 30; i++)
                send_item(FN_ENCODE, LETTER_W'($urandom_range(25)), 0, 1'b0);
        join
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        func = '0;
        letter = '0;
        count_value = '0;
        code_bit = 1'b0;
        errors = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        idle_en = 1'b1;
        hold_rx = 1'b0;
        olen = 0;
        root = 0;
        built = 0;
        cursor = 0;
        for (int l = 0; l < NLET; l++)
            cnt[l] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_tree();
        test_directed_tree();
        drain_results();
        test_full_alphabet();
        test_backpressure();
        idle_en = 1'b0;
        test_random(300);
        idle_en = 1'b1;
        test_random(1000);
        drain_results();

        $display("covered %0d items and %0d results: builds, encode, decode, saturation",
                 items_sent, results_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
